@@ rtl/bvs_pkg.sv @@
// ============================================================================
// bvs_pkg
// Shared types and constants for the bencode value skipper.
// ============================================================================
package bvs_pkg;

    // Width of the nesting depth seen on the result port.
    localparam int NEST_W = 6;

    // Parse modes.
    typedef enum logic [1:0] {
        MODE_EXPECT = 2'd0,
        MODE_INT    = 2'd1,
        MODE_LEN    = 2'd2,
        MODE_STR    = 2'd3
    } bvs_mode_t;

    // Characters that steer the parser.
    localparam logic [7:0] CH_DICT  = 8'h64; // 'd'
    localparam logic [7:0] CH_LIST  = 8'h6C; // 'l'
    localparam logic [7:0] CH_INT   = 8'h69; // 'i'
    localparam logic [7:0] CH_END   = 8'h65; // 'e'
    localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
    localparam logic [7:0] CH_NINE  = 8'h39; // '9'

    // One result word.
    typedef struct packed {
        logic              value_done;
        logic              parse_error;
        logic [NEST_W-1:0] nest_level;
    } bvs_result_t;

endpackage

@@ rtl/bvs_step.sv @@
// ============================================================================
// bvs_step
// Next-state and result logic of the parser for one stream byte.
// ============================================================================
module bvs_step
    import bvs_pkg::*;
#(
    parameter int MAX_DEPTH = 32,
    parameter int LEN_BITS  = 32
) (
    input  logic [7:0]          stream_byte,
    input  bvs_mode_t           mode,
    input  logic [NEST_W-1:0]   depth,
    input  logic [LEN_BITS-1:0] remaining,
    output bvs_mode_t           mode_next,
    output logic [NEST_W-1:0]   depth_next,
    output logic [LEN_BITS-1:0] remaining_next,
    output bvs_result_t         result
);

    localparam logic [NEST_W-1:0] DEPTH_LIMIT =
        NEST_W'((MAX_DEPTH < 63) ? MAX_DEPTH : 63);

    logic                is_digit;
    logic [3:0]          digit_val;
    logic [LEN_BITS-1:0] len_times10;
    logic [LEN_BITS-1:0] rem_dec;
    logic                done;
    logic                err;
    bvs_mode_t           mode_ok;
    logic [NEST_W-1:0]   depth_ok;
    logic [LEN_BITS-1:0] rem_ok;

    assign is_digit    = (stream_byte >= CH_ZERO) && (stream_byte <= CH_NINE);
    assign digit_val   = 4'(stream_byte - CH_ZERO);
    // Ten times the length as two shifted copies added together.
    assign len_times10 = (remaining << 3) + (remaining << 1);
    assign rem_dec     = remaining - LEN_BITS'(1);

    always_comb begin
        mode_ok  = mode;
        depth_ok = depth;
        rem_ok   = remaining;
        done     = 1'b0;
        err      = 1'b0;
        unique case (mode)
            MODE_EXPECT: begin
                if (stream_byte == CH_DICT || stream_byte == CH_LIST) begin
                    if (depth >= DEPTH_LIMIT) begin
                        err = 1'b1;
                    end else begin
                        depth_ok = depth + NEST_W'(1);
                    end
                end else if (stream_byte == CH_END) begin
                    if (depth == '0) begin
                        err = 1'b1;
                    end else begin
                        depth_ok = depth - NEST_W'(1);
                        done     = (depth == NEST_W'(1));
                    end
                end else if (stream_byte == CH_INT) begin
                    mode_ok = MODE_INT;
                end else if (is_digit) begin
                    mode_ok = MODE_LEN;
                    rem_ok  = LEN_BITS'(digit_val);
                end else begin
                    err = 1'b1;
                end
            end
            MODE_INT: begin
                if (stream_byte == CH_END) begin
                    mode_ok = MODE_EXPECT;
                    done    = (depth == '0);
                end
            end
            MODE_LEN: begin
                if (is_digit) begin
                    rem_ok = len_times10 + LEN_BITS'(digit_val);
                end else if (remaining == '0) begin
                    // A zero-length string ends on its separator.
                    mode_ok = MODE_EXPECT;
                    done    = (depth == '0);
                end else begin
                    mode_ok = MODE_STR;
                end
            end
            MODE_STR: begin
                rem_ok = rem_dec;
                if (rem_dec == '0) begin
                    mode_ok = MODE_EXPECT;
                    done    = (depth == '0);
                end
            end
            default: begin
                mode_ok = MODE_EXPECT;
            end
        endcase
    end

    // An error drops everything back to the reset state.
    assign mode_next          = err ? MODE_EXPECT : mode_ok;
    assign depth_next         = err ? '0 : depth_ok;
    assign remaining_next     = err ? '0 : rem_ok;
    assign result.value_done  = done & ~err;
    assign result.parse_error = err;
    assign result.nest_level  = depth_next;

endmodule

@@ rtl/bencode_value_skipper.sv @@
// ============================================================================
// bencode_value_skipper
// Finds the end of each complete top-level value in a bencoded byte stream.
// ============================================================================
// The block takes one byte word per cycle on the s_ channel and returns one
// result word per byte on the m_ channel, in the cycle after the byte is
// accepted. Each result flags whether that byte ended a complete top-level
// value, whether it was a parse error (an unexpected byte, a closing 'e' with
// nothing open, or a container opened past the depth limit), and the nesting
// depth after the byte. An error returns the parser to its idle state. The
// sustained rate is one byte per cycle: the mode, depth and string-length
// update is a single registered step, and the result register is refilled in
// the same cycle that its word is taken, so s_ready only drops while a
// result is held by m_ready low. MAX_DEPTH sets the depth limit (capped at
// 63 by the six-bit depth), and LEN_BITS sets the width of the string length
// counter, which wraps on overlong decimal lengths.
// ============================================================================
module bencode_value_skipper
    import bvs_pkg::*;
#(
    parameter int MAX_DEPTH = 32,
    parameter int LEN_BITS  = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_stream_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_value_done,
    output logic              m_parse_error,
    output logic [NEST_W-1:0] m_nest_level
);

    // Parser state.
    bvs_mode_t           mode_reg;
    bvs_mode_t           mode_next;
    logic [NEST_W-1:0]   depth_reg;
    logic [NEST_W-1:0]   depth_next;
    logic [LEN_BITS-1:0] remaining_reg;
    logic [LEN_BITS-1:0] remaining_next;

    // Result register.
    logic                m_valid_reg;
    bvs_result_t         result_reg;
    bvs_result_t         result_next;

    logic                accept;

    // A new byte may enter whenever the result register is empty or its
    // word leaves in this same cycle.
    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;

    bvs_step #(
        .MAX_DEPTH (MAX_DEPTH),
        .LEN_BITS  (LEN_BITS)
    ) u_step (
        .stream_byte    (s_stream_byte),
        .mode           (mode_reg),
        .depth          (depth_reg),
        .remaining      (remaining_reg),
        .mode_next      (mode_next),
        .depth_next     (depth_next),
        .remaining_next (remaining_next),
        .result         (result_next)
    );

    // The parser state advances only on an accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_EXPECT;
            depth_reg     <= '0;
            remaining_reg <= '0;
        end else if (accept) begin
            mode_reg      <= mode_next;
            depth_reg     <= depth_next;
            remaining_reg <= remaining_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload is loaded with the byte; it needs no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_value_done  = result_reg.value_done;
    assign m_parse_error = result_reg.parse_error;
    assign m_nest_level  = result_reg.nest_level;

endmodule

@@ rtl/bvs_checker.sv @@
// ============================================================================
// bvs_checker
// Port-level checks for the bencode value skipper, bound to its top level.
// ============================================================================
module bvs_checker
    import bvs_pkg::*;
#(
    parameter int MAX_DEPTH = 32
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_value_done,
    input logic              m_parse_error,
    input logic [NEST_W-1:0] m_nest_level
);

    localparam logic [NEST_W-1:0] DEPTH_LIMIT =
        NEST_W'((MAX_DEPTH < 63) ? MAX_DEPTH : 63);

    // An error word never also reports a finished value, and it shows the
    // parser back at the top level.
    a_error_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_parse_error |-> !m_value_done && m_nest_level == '0)
        else $error("error word with done set or nonzero depth");

    // A value can only finish at the top level.
    a_done_top : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_value_done |-> m_nest_level == '0)
        else $error("value done reported inside a container");

    // The depth never goes past the limit.
    a_depth_limit : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_nest_level <= DEPTH_LIMIT)
        else $error("nesting depth beyond limit");

    // A byte accepted into an empty result register shows up next cycle.
    a_one_cycle : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted byte produced no result word");

    // A stalled result word holds.
    a_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_done)
            && $stable(m_parse_error) && $stable(m_nest_level))
        else $error("stalled result word changed");

endmodule

bind bencode_value_skipper bvs_checker #(
    .MAX_DEPTH (MAX_DEPTH)
) u_bvs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_value_done  (m_value_done),
    .m_parse_error (m_parse_error),
    .m_nest_level  (m_nest_level)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking testbench for the bencode value skipper.
// ============================================================================
// A short directed sequence and then several hundred random bytes, mostly
// well-formed values with random content, are fed through the s_ channel. An
// in-bench parser predicts the result word for every accepted byte, and the
// monitor checks each m_ word against the oldest prediction. Both sides idle
// and stall at random.
// ============================================================================
module tb_top;
    import bvs_pkg::*;

    localparam int MAX_DEPTH = 32;
    localparam int LEN_BITS  = 32;
    // The six-bit depth counter caps the usable nesting limit.
    localparam int DEPTH_CAP = (MAX_DEPTH < 63) ? MAX_DEPTH : 63;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_WORDS = 400;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [7:0]        s_stream_byte = 8'h00;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_value_done;
    logic              m_parse_error;
    logic [NEST_W-1:0] m_nest_level;

    bencode_value_skipper #(
        .MAX_DEPTH(MAX_DEPTH),
        .LEN_BITS (LEN_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_stream_byte(s_stream_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value_done (m_value_done),
        .m_parse_error(m_parse_error),
        .m_nest_level (m_nest_level)
    );

    always #5 aclk = ~aclk;

    // One byte waiting to be sent. The gap is the number of idle cycles the
    // sender leaves after this word is taken. A word marked sync is held back
    // until every earlier byte has produced its result.
    typedef struct {
        logic [7:0]  data;
        logic        sync;
        int unsigned gap;
    } pending_t;

    pending_t    stream_q[$];
    bvs_result_t result_q[$];

    int  n_sent = 0;
    int  n_got = 0;
    int  errors = 0;
    int  n_queued = 0;
    logic tx_calm = 1'b0;
    logic hold_next = 1'b0;

    // ------------------------------------------------------------------------
    // Parser state as the block should hold it.
    // ------------------------------------------------------------------------
    bvs_mode_t           pmode = MODE_EXPECT;
    logic [NEST_W-1:0]   depth = '0;
    logic [LEN_BITS-1:0] str_left = '0;

    // Advances the parser state by one byte and returns the result word that
    // the block should emit for it.
    function automatic bvs_result_t parse_byte(input logic [7:0] ch);
        bvs_result_t         r;
        logic                fault;
        logic                is_num;
        logic [LEN_BITS-1:0] digit;
        fault = 1'b0;
        r.value_done = 1'b0;
        is_num = (ch >= CH_ZERO) && (ch <= CH_NINE);
        digit = LEN_BITS'(ch - CH_ZERO);
        case (pmode)
            MODE_EXPECT: begin
                if (ch == CH_DICT || ch == CH_LIST) begin
                    // Opening past the limit is a fault, not a clamp.
                    if (depth >= DEPTH_CAP)
                        fault = 1'b1;
                    else
                        depth = depth + 1'b1;
                end else if (ch == CH_END) begin
                    if (depth == 0) begin
                        fault = 1'b1;
                    end else begin
                        depth = depth - 1'b1;
                        r.value_done = (depth == 0);
                    end
                end else if (ch == CH_INT) begin
                    pmode = MODE_INT;
                end else if (is_num) begin
                    pmode = MODE_LEN;
                    str_left = digit;
                end else begin
                    fault = 1'b1;
                end
            end
            MODE_INT: begin
                // The integer body is not checked at all.
                if (ch == CH_END) begin
                    pmode = MODE_EXPECT;
                    r.value_done = (depth == 0);
                end
            end
            MODE_LEN: begin
                if (is_num) begin
                    // Overlong lengths wrap at the counter width.
                    str_left = str_left * 10 + digit;
                end else if (str_left == 0) begin
                    // A zero-length string ends on its separator.
                    pmode = MODE_EXPECT;
                    r.value_done = (depth == 0);
                end else begin
                    pmode = MODE_STR;
                end
            end
            default: begin
                str_left = str_left - 1'b1;
                if (str_left == 0) begin
                    pmode = MODE_EXPECT;
                    r.value_done = (depth == 0);
                end
            end
        endcase
        if (fault) begin
            pmode = MODE_EXPECT;
            depth = '0;
            str_left = '0;
            r.value_done = 1'b0;
        end
        r.parse_error = fault;
        r.nest_level = depth;
        return r;
    endfunction

    // Idle cycles for one word: none in calm stretches, otherwise mostly
    // short gaps with the occasional long one.
    function automatic int unsigned draw_wait(input logic calm);
        if (calm)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 16);
        return $urandom_range(0, 2);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders. They only fill the pending queue.
    // ------------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b);
        pending_t p;
        p.data = b;
        p.sync = hold_next;
        p.gap = draw_wait(tx_calm);
        hold_next = 1'b0;
        stream_q.push_back(p);
        n_queued++;
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++)
            put_byte(s[k]);
    endtask

    // Any byte that is not a decimal digit works as the length separator.
    task automatic put_separator();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b >= CH_ZERO && b <= CH_NINE);
        put_byte(b);
    endtask

    // One well-formed value. Nesting is bounded by the budget.
    task automatic put_value(input int budget);
        int         kind;
        int         n;
        logic [7:0] b;
        kind = $urandom_range(0, (budget > 0) ? 3 : 1);
        case (kind)
            0: begin
                put_byte(CH_INT);
                n = $urandom_range(0, 4);
                repeat (n) begin
                    b = 8'($urandom_range(0, 255));
                    put_byte((b == CH_END) ? 8'h2D : b);
                end
                put_byte(CH_END);
            end
            1: begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 5);
                if ($urandom_range(0, 7) == 0)
                    put_byte(CH_ZERO);
                put_text($sformatf("%0d", n));
                put_separator();
                // Payload bytes are arbitrary, control characters included.
                repeat (n) put_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                put_byte((kind == 2) ? CH_LIST : CH_DICT);
                n = $urandom_range(0, 3);
                repeat (n) put_value(budget - 1);
                put_byte(CH_END);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents pending bytes on the s_ channel and records the
    // prediction for each byte that is accepted.
    // ------------------------------------------------------------------------
    int unsigned tx_wait = 0;

    always @(posedge aclk) begin
        logic       nxt_valid;
        logic [7:0] nxt_data;
        int         sent_now;
        pending_t   p;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_stream_byte <= 8'h00;
        end else begin
            nxt_valid = s_valid;
            nxt_data = s_stream_byte;
            sent_now = n_sent;
            if (s_valid && s_ready) begin
                result_q.push_back(parse_byte(s_stream_byte));
                sent_now = n_sent + 1;
                n_sent <= sent_now;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (tx_wait > 0) begin
                    tx_wait = tx_wait - 1;
                end else if (stream_q.size() > 0 &&
                             !(stream_q[0].sync && sent_now != n_got)) begin
                    p = stream_q.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data = p.data;
                    tx_wait = p.gap;
                end
            end
            // The payload only changes when a new word goes out, so a held
            // word keeps its byte.
            s_valid <= nxt_valid;
            s_stream_byte <= nxt_data;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes result words with random back-pressure and checks each
    // one field by field against the oldest prediction.
    // ------------------------------------------------------------------------
    int unsigned rx_wait = 0;
    logic        rx_calm = 1'b0;

    always @(posedge aclk) begin
        bvs_result_t got;
        bvs_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.value_done = m_value_done;
                got.parse_error = m_parse_error;
                got.nest_level = m_nest_level;
                if (result_q.size() == 0) begin
                    if (errors < 10)
                        $display({"tb_top: result word with nothing pending: ",
                                  "done=%0b err=%0b depth=%0d"},
                                 got.value_done, got.parse_error, got.nest_level);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (got.value_done !== want.value_done ||
                        got.parse_error !== want.parse_error ||
                        got.nest_level !== want.nest_level) begin
                        if (errors < 10)
                            $display({"tb_top: word %0d expected done=%0b err=%0b ",
                                      "depth=%0d, got done=%0b err=%0b depth=%0d"},
                                     n_got, want.value_done, want.parse_error,
                                     want.nest_level, got.value_done,
                                     got.parse_error, got.nest_level);
                        errors++;
                    end
                end
                n_got <= n_got + 1;
                // Switch between stalling and stall-free stretches now and then.
                if ($urandom_range(0, 39) == 0)
                    rx_calm = ~rx_calm;
                rx_wait = draw_wait(rx_calm);
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
            end
            m_ready <= (rx_wait == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no word moves on either channel for too long.
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int pick;
        int n;

        // Directed part: empty containers, integers with and without a body,
        // zero-length and short strings, a close with nothing open, unknown
        // bytes at both ends of the byte range, and a nested element.
        put_text("de");
        put_text("le");
        put_text("ie");
        put_text("i-7e");
        put_text("0:");
        put_text("2:ab");
        put_byte(CH_END);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text("l0:e");

        // The random part starts only after every directed result is in.
        hold_next = 1'b1;
        n_queued = 0;
        while (n_queued < RANDOM_WORDS) begin
            if ($urandom_range(0, 14) == 0)
                tx_calm = ~tx_calm;
            if ($urandom_range(0, 19) == 0)
                hold_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                put_value(3);
            end else if (pick < 88) begin
                put_byte(8'($urandom_range(0, 255)));
            end else if (pick < 92) begin
                // A value followed by a stray close.
                put_value(1);
                put_byte(CH_END);
            end else if (pick < 96) begin
                // Deep nesting around the depth limit, then closes.
                n = $urandom_range(DEPTH_CAP - 2, DEPTH_CAP + 2);
                repeat (n) put_byte($urandom_range(0, 1) ? CH_LIST : CH_DICT);
                repeat (n) put_byte(CH_END);
            end else if (pick < 98) begin
                // Length that wraps to ten.
                put_text("4294967306");
                put_separator();
                repeat (10) put_byte(8'($urandom_range(0, 255)));
            end else begin
                // Length that wraps to zero, so the separator ends it.
                put_text("4294967296");
                put_separator();
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Sampled on the falling edge so every update of the rising edge has
        // settled.
        do
            @(negedge aclk);
        while (stream_q.size() != 0 || s_valid || n_got != n_sent);
        repeat (8) @(posedge aclk);

        if (result_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
